// ----- hdl/bas_pkg.sv -----
// shared constants, item types and codes of the adjacency store
`timescale 1ns / 1ps

package bas_pkg;

  localparam int NODES       = 256;
  localparam int EDGES       = 8;
  localparam int POINT_WIDTH = 64;

  // item field widths
  localparam int OP_W   = 3;
  localparam int IDX_W  = 8;
  localparam int SLOT_W = 3;
  localparam int PTF_W  = 64;
  localparam int AREA_W = 16;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 4;
  localparam int VT_W   = 9;

  // storage geometry
  localparam int NODE_AW    = $clog2(NODES);
  localparam int VC_W       = $clog2(NODES + 1);
  localparam int DEG_W      = $clog2(EDGES + 1);
  localparam int ADJ_SLOT_W = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int ADJ_AW     = NODE_AW + ADJ_SLOT_W;
  localparam int ADJ_DEPTH  = NODES << ADJ_SLOT_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD_NODE  = 3'd1,
    OP_ADD_EDGE  = 3'd2,
    OP_INC_AREA  = 3'd3,
    OP_SET_AREA  = 3'd4,
    OP_READ_NODE = 3'd5,
    OP_READ_EDGE = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_NODES_FULL = 2'd1,
    ST_EDGES_FULL = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_WR_B,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  node_a;
    logic [IDX_W-1:0]  node_b;
    logic [SLOT_W-1:0] edge_slot;
    logic [PTF_W-1:0]  point_value;
    logic [AREA_W-1:0] area_value;
  } req_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  node_index;
    logic [PTF_W-1:0]  node_point;
    logic [AREA_W-1:0] area_count;
    logic [CNT_W-1:0]  edge_count;
    logic [CNT_W-1:0]  free_edges;
    logic              has_free_edge;
    logic [IDX_W-1:0]  neighbor;
    logic [VT_W-1:0]   vertex_total;
    logic              limit_near;
  } rsp_item_t;

endpackage

// ----- hdl/bas_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps

interface bas_req_if import bas_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bas_rsp_if import bas_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- hdl/bounded_adjacency_store.sv -----
// graph store with per-vertex point, area count and bounded adjacency list
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, node_a, node_b, edge_slot, point_value, area_value
//   rsp      out  valid/ready   status, node_index, node_point, area_count, edge_count,
//                               free_edges, has_free_edge, neighbor, vertex_total, limit_near
//
// one item at a time: clear, add node, area and read ops pass through S_RD_A and
// S_RESULT; a self edge or a refused edge adds S_RD_B, and an edge added between two
// vertices adds S_WR_B as well, since the single degree/adjacency write port serves
// the two vertices, which are read and written one after the other
// rsp is a register: the next item is taken while a result waits; a full rsp
// register holds the block in its last step until the result is taken
// synchronous reset clears the vertex count and handshake state; no clearing pass
`timescale 1ns / 1ps

module bounded_adjacency_store import bas_pkg::*; (
  input logic       clk,
  input logic       rst,
  bas_req_if.sink   req,
  bas_rsp_if.source rsp
);

  state_t            state, state_next;
  logic [VC_W-1:0]   vc, vc_next;
  req_item_t         item;
  logic [DEG_W-1:0]  deg_a;
  logic [DEG_W-1:0]  deg_b;
  rsp_item_t         res, res_next;
  logic              rsp_valid;
  rsp_item_t         rsp_item;
  logic              accept;
  logic              rsp_free;

  logic                   pt_we, area_we, deg_we, adj_we;
  logic                   pt_re, deg_re;
  logic [NODE_AW-1:0]     pt_waddr, area_waddr, deg_waddr, rd_addr, deg_raddr;
  logic [POINT_WIDTH-1:0] pt_wdata, pt_rdata;
  logic [AREA_W-1:0]      area_wdata, area_rdata;
  logic [DEG_W-1:0]       deg_wdata, deg_rdata;
  logic [ADJ_AW-1:0]      adj_waddr, adj_raddr;
  logic [IDX_W-1:0]       adj_wdata, adj_rdata;

  logic a_ok, b_ok, self_edge, edge_room, edge_pair;

  function automatic logic idx_ok(logic [IDX_W-1:0] i, logic [VC_W-1:0] n);
    return (IDX_W + VC_W)'(i) < (IDX_W + VC_W)'(n);
  endfunction

  // result fields for a vertex that is shown
  function automatic rsp_item_t show(rsp_item_t r, logic [POINT_WIDTH-1:0] p,
                                     logic [AREA_W-1:0] ar, logic [DEG_W-1:0] d);
    rsp_item_t o;
    o = r;
    o.node_point    = PTF_W'(p);
    o.area_count    = ar;
    o.edge_count    = CNT_W'(d);
    o.free_edges    = CNT_W'(DEG_W'(EDGES) - d);
    o.has_free_edge = d < DEG_W'(EDGES);
    return o;
  endfunction

  assign accept   = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;
  assign rd_addr  = NODE_AW'(req.item.node_a);
  assign pt_re    = accept;
  assign deg_re   = accept || (state == S_RD_A);
  assign deg_raddr = (state == S_RD_A) ? NODE_AW'(item.node_b) : rd_addr;
  assign adj_raddr = {NODE_AW'(req.item.node_a), ADJ_SLOT_W'(req.item.edge_slot)};

  // edge checks, valid in S_RD_B where deg_rdata holds node_b's degree
  always_comb begin
    a_ok      = idx_ok(item.node_a, vc);
    b_ok      = idx_ok(item.node_b, vc);
    self_edge = item.node_a == item.node_b;
    if (self_edge) begin
      edge_room = (DEG_W + 1)'(deg_a) + (DEG_W + 1)'(2) <= (DEG_W + 1)'(EDGES);
    end else begin
      edge_room = (deg_a < DEG_W'(EDGES)) && (deg_rdata < DEG_W'(EDGES));
    end
    edge_pair = a_ok && b_ok && edge_room && !self_edge;
  end

  bas_ram #(.WIDTH(POINT_WIDTH), .DEPTH(NODES)) u_point_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .re(pt_re), .raddr(rd_addr), .rdata(pt_rdata)
  );

  bas_ram #(.WIDTH(AREA_W), .DEPTH(NODES)) u_area_ram (
    .clk(clk), .we(area_we), .waddr(area_waddr), .wdata(area_wdata),
    .re(pt_re), .raddr(rd_addr), .rdata(area_rdata)
  );

  bas_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_degree_ram (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata)
  );

  bas_ram #(.WIDTH(IDX_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .re(pt_re), .raddr(adj_raddr), .rdata(adj_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_RD_A;
      end
      S_RD_A: begin
        state_next = (item.op == OP_ADD_EDGE) ? S_RD_B : S_RESULT;
      end
      S_RD_B: begin
        state_next = edge_pair ? S_WR_B : S_RESULT;
      end
      S_WR_B: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory writes and result
  always_comb begin
    req.ready  = 1'b0;
    vc_next    = vc;
    res_next   = res;
    pt_we      = 1'b0;
    pt_waddr   = NODE_AW'(vc);
    pt_wdata   = POINT_WIDTH'(item.point_value);
    area_we    = 1'b0;
    area_waddr = NODE_AW'(item.node_a);
    area_wdata = '0;
    deg_we     = 1'b0;
    deg_waddr  = NODE_AW'(item.node_a);
    deg_wdata  = '0;
    adj_we     = 1'b0;
    adj_waddr  = {NODE_AW'(item.node_a), ADJ_SLOT_W'(deg_a)};
    adj_wdata  = item.node_b;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_RD_A: begin
        res_next = '0;
        res_next.status = ST_OK;
        case (op_t'(item.op))
          OP_CLEAR: begin
            vc_next = '0;
          end
          OP_ADD_NODE: begin
            if (32'(vc) >= 32'(NODES)) begin
              res_next.status = ST_NODES_FULL;
            end else begin
              pt_we      = 1'b1;
              area_we    = 1'b1;
              area_waddr = NODE_AW'(vc);
              deg_we     = 1'b1;
              deg_waddr  = NODE_AW'(vc);
              vc_next    = vc + VC_W'(1);
              res_next.node_index = IDX_W'(vc);
              res_next = show(res_next, POINT_WIDTH'(item.point_value), '0, '0);
            end
          end
          OP_INC_AREA, OP_SET_AREA, OP_READ_NODE: begin
            if (!a_ok) begin
              res_next.status = ST_RANGE;
            end else begin
              area_wdata = area_rdata;
              if (item.op == OP_INC_AREA) begin
                area_we    = 1'b1;
                area_wdata = area_rdata + AREA_W'(1);
              end else if (item.op == OP_SET_AREA) begin
                area_we    = 1'b1;
                area_wdata = item.area_value;
              end
              res_next = show(res_next, pt_rdata, area_wdata, deg_rdata);
            end
          end
          OP_READ_EDGE: begin
            if (!a_ok || 32'(item.edge_slot) >= 32'(EDGES)) begin
              res_next.status = ST_RANGE;
            end else begin
              res_next.neighbor = adj_rdata;
              res_next = show(res_next, pt_rdata, area_rdata, deg_rdata);
            end
          end
          default: ;
        endcase
        res_next.vertex_total = VT_W'(vc_next);
        res_next.limit_near   = (VC_W + 1)'(vc_next) + (VC_W + 1)'(1) >= (VC_W + 1)'(NODES);
      end
      S_RD_B: begin
        res_next = '0;
        res_next.vertex_total = VT_W'(vc);
        res_next.limit_near   = (VC_W + 1)'(vc) + (VC_W + 1)'(1) >= (VC_W + 1)'(NODES);
        if (!a_ok || !b_ok) begin
          res_next.status = ST_RANGE;
        end else if (!edge_room) begin
          res_next.status = ST_EDGES_FULL;
        end else begin
          res_next.status = ST_OK;
          deg_we = 1'b1;
          adj_we = 1'b1;
          // a self edge takes one slot but counts twice
          deg_wdata = self_edge ? deg_a + DEG_W'(2) : deg_a + DEG_W'(1);
          res_next = show(res_next, pt_rdata, area_rdata, deg_wdata);
        end
      end
      S_WR_B: begin
        deg_we    = 1'b1;
        deg_waddr = NODE_AW'(item.node_b);
        deg_wdata = deg_b + DEG_W'(1);
        adj_we    = 1'b1;
        adj_waddr = {NODE_AW'(item.node_b), ADJ_SLOT_W'(deg_b)};
        adj_wdata = item.node_a;
      end
      S_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vc        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      vc    <= vc_next;
      if (state == S_RESULT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= req.item;
    if (state == S_RD_A) deg_a <= deg_rdata;
    if (state == S_RD_B) deg_b <= deg_rdata;
    res <= res_next;
    if (state == S_RESULT && rsp_free) rsp_item <= res;
  end

  assign rsp.valid = rsp_valid;
  assign rsp.item  = rsp_item;

endmodule

// ----- hdl/bas_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module bas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bas_chk.sv -----
// port-level checks of the adjacency store, bound to the top level
`timescale 1ns / 1ps

module bas_chk import bas_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [ST_W-1:0]  status,
  input logic [PTF_W-1:0] node_point,
  input logic [AREA_W-1:0] area_count,
  input logic [CNT_W-1:0] edge_count,
  input logic [CNT_W-1:0] free_edges,
  input logic             has_free_edge,
  input logic [VT_W-1:0]  vertex_total,
  input logic             limit_near
);

  // a result stays offered until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp item dropped while stalled");

  // only one item is worked on at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while busy");

  // refused operations show no vertex
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |->
      node_point == '0 && area_count == '0 && edge_count == '0 && !has_free_edge)
    else $error("refused item carries vertex fields");

  a_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> limit_near == (32'(vertex_total) + 1 >= NODES))
    else $error("limit_near disagrees with vertex_total");

  a_slots: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && has_free_edge |->
      (CNT_W + 1)'(edge_count) + (CNT_W + 1)'(free_edges) == (CNT_W + 1)'(EDGES))
    else $error("edge_count and free_edges do not add up");

endmodule

bind bounded_adjacency_store bas_chk u_bas_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.item.status),
  .node_point   (rsp.item.node_point),
  .area_count   (rsp.item.area_count),
  .edge_count   (rsp.item.edge_count),
  .free_edges   (rsp.item.free_edges),
  .has_free_edge(rsp.item.has_free_edge),
  .vertex_total (rsp.item.vertex_total),
  .limit_near   (rsp.item.limit_near)
);
